FILE: sv/http_request_line_parser_assert.svh
// Assertion macros used by the port-level checker of the request line parser.
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define HRLP_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hrlp assertion failed");

// Clocked assertion on the block's own clock and reset.
`define HRLP_ASSERT(label, prop) \
  `HRLP_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

FILE: sv/hrlp_pkg.sv
// Package with types, constants and helper functions of the request line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

  localparam int PosW           = 16;
  localparam int PathLimitW     = 13;
  localparam int MaxRequestBytesDef = 65535;
  localparam int QueueDepthDef  = 4;

  localparam logic [PathLimitW-1:0] PathLimitReset = 13'd256;
  localparam logic [PathLimitW-1:0] PathLenSat     = 13'h1FFF;

  // Characters that steer the parse.
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] ByteQmark = 8'h3F;
  localparam logic [7:0] ByteSlash = 8'h2F;
  localparam logic [7:0] CaseBit   = 8'h20;

  // Method codes.
  localparam logic [1:0] MethodNone    = 2'd0;
  localparam logic [1:0] MethodGet     = 2'd1;
  localparam logic [1:0] MethodPost    = 2'd2;
  localparam logic [1:0] MethodOptions = 2'd3;

  // Status codes of the final result.
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusNoMethod = 3'd1;
  localparam logic [2:0] StatusNoBody   = 3'd2;
  localparam logic [2:0] StatusNoPath   = 3'd3;
  localparam logic [2:0] StatusTooLong  = 3'd4;

  // Result kinds.
  localparam logic KindPath  = 1'b0;
  localparam logic KindFinal = 1'b1;

  // Progress through CR LF CR LF.
  localparam logic [2:0] BlankNone    = 3'd0;
  localparam logic [2:0] BlankCr      = 3'd1;
  localparam logic [2:0] BlankCrLf    = 3'd2;
  localparam logic [2:0] BlankCrLfCr  = 3'd3;
  localparam logic [2:0] BlankFound   = 3'd4;

  // Lower-case spelling of each method, indexed by method code minus one.
  localparam logic [7:0] MethodChars [3][8] = '{
    '{8'h67, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h6F, 8'h73, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6F, 8'h70, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h73, 8'h00}
  };

  typedef enum logic [5:0] {
    PhSpace  = 6'b000001,
    PhMethod = 6'b000010,
    PhSeek   = 6'b000100,
    PhPath   = 6'b001000,
    PhDone   = 6'b010000,
    PhFail   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic            result_kind;
    logic [7:0]      path_byte;
    logic [1:0]      method_code;
    logic [2:0]      status_code;
    logic [PosW-1:0] body_offset;
    logic            run_end;
  } out_beat_t;

  // One queue entry: what a single input byte asks the back end to emit.
  typedef struct packed {
    logic            has_path;
    logic            has_final;
    logic [7:0]      path_byte;
    logic [1:0]      method_code;
    logic [2:0]      status_code;
    logic [PosW-1:0] body_offset;
  } work_t;

  function automatic logic [2:0] method_len(logic [1:0] m);
    logic [2:0] len;
    case (m)
      MethodGet:     len = 3'd3;
      MethodPost:    len = 3'd4;
      MethodOptions: len = 3'd7;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] method_char(logic [1:0] m, logic [2:0] idx);
    logic [1:0] row;
    logic [7:0] ch;
    row = m - 2'd1;
    if (m == MethodNone) begin
      ch = 8'h00;
    end else begin
      ch = MethodChars[row][idx];
    end
    return ch;
  endfunction

endpackage

FILE: sv/hrlp_front.sv
// Front end: takes request bytes, tracks the parse and classifies each byte.
`timescale 1ns / 1ps

module hrlp_front import hrlp_pkg::*; #(
  parameter int MaxRequestBytes = MaxRequestBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [PathLimitW-1:0] cfg_wdata_i,
  input  logic                  accept_i,
  input  in_beat_t              in_beat_i,
  output logic                  push_o,
  output work_t                 work_o
);

  localparam logic [PosW-1:0] PosMax = PosW'(MaxRequestBytes);

  logic [PathLimitW-1:0] path_limit_q;
  phase_e                phase_q, phase_d;
  logic [2:0]            prog_q, prog_d;
  logic [1:0]            mfound_q, mfound_d;
  logic [PosW-1:0]       pos_q, pos_d;
  logic [PathLimitW-1:0] plen_q, plen_d;
  logic [2:0]            blank_q, blank_d;
  logic [PosW-1:0]       body_q, body_d;
  logic                  pstart_q, pstart_d;

  logic [7:0] b;
  logic [7:0] lc;
  logic       last;
  logic       run_m;
  logic [1:0] m_f;
  logic [2:0] m_p;
  logic       past_before;
  logic       past_after;
  logic [1:0] mc;
  logic       has_body;

  assign b    = in_beat_i.data_byte;
  assign last = in_beat_i.last_byte;
  assign lc   = b | CaseBit;

  always_comb begin
    phase_d  = phase_q;
    prog_d   = prog_q;
    mfound_d = mfound_q;
    pos_d    = pos_q;
    plen_d   = plen_q;
    blank_d  = blank_q;
    body_d   = body_q;
    pstart_d = pstart_q;
    run_m    = 1'b0;
    m_f      = mfound_q;
    m_p      = prog_q;
    mc       = MethodNone;
    has_body = 1'b0;
    work_o   = '0;

    unique case (phase_q)
      PhSpace: begin
        if (b != ByteSpace) begin
          run_m   = 1'b1;
          m_p     = 3'd0;
          phase_d = PhMethod;
          if (lc == method_char(MethodGet, 3'd0)) begin
            m_f = MethodGet;
          end else if (lc == method_char(MethodPost, 3'd0)) begin
            m_f = MethodPost;
          end else if (lc == method_char(MethodOptions, 3'd0)) begin
            m_f = MethodOptions;
          end else begin
            m_f = MethodNone;
          end
        end
      end
      PhMethod: run_m = 1'b1;
      PhSeek: begin
        if (b == ByteSlash && !last) begin
          pstart_d        = 1'b1;
          plen_d          = PathLimitW'(1);
          phase_d         = PhPath;
          work_o.has_path = 1'b1;
        end
      end
      PhPath: begin
        if (b == ByteSpace || b == ByteCr || b == ByteLf || b == ByteQmark) begin
          phase_d = PhDone;
        end else begin
          if (plen_q < PathLenSat) begin
            plen_d = plen_q + PathLimitW'(1);
          end
          work_o.has_path = 1'b1;
        end
      end
      PhDone, PhFail: ;
      default: ;
    endcase

    // One letter of the method; the last letter needs a byte after it.
    if (run_m) begin
      mfound_d = m_f;
      prog_d   = m_p;
      if (m_f != MethodNone && m_p < method_len(m_f) && lc == method_char(m_f, m_p)) begin
        prog_d = m_p + 3'd1;
        if (m_p + 3'd1 == method_len(m_f)) begin
          if (last) begin
            phase_d  = PhFail;
            mfound_d = MethodNone;
          end else begin
            phase_d = PhSeek;
          end
        end
      end else begin
        phase_d  = PhFail;
        mfound_d = MethodNone;
      end
    end

    // Blank line search for a POST body, running alongside the path.
    past_before = (phase_q == PhSeek) || (phase_q == PhPath) || (phase_q == PhDone);
    if (past_before && mfound_q == MethodPost && blank_q != BlankFound) begin
      if (b == ByteCr) begin
        blank_d = (blank_q == BlankCrLf) ? BlankCrLfCr : BlankCr;
      end else if (b == ByteLf) begin
        blank_d = (blank_q == BlankCr)     ? BlankCrLf :
                  (blank_q == BlankCrLfCr) ? BlankFound : BlankNone;
      end else begin
        blank_d = BlankNone;
      end
      if (blank_d == BlankFound) begin
        if (last) begin
          blank_d = BlankNone;
        end else begin
          body_d = (pos_q < PosMax) ? pos_q + PosW'(1) : PosMax;
        end
      end
    end

    if (pos_q < PosMax) begin
      pos_d = pos_q + PosW'(1);
    end

    work_o.path_byte   = work_o.has_path ? b : 8'h00;
    work_o.method_code = mfound_d;

    if (last) begin
      past_after = (phase_d == PhSeek) || (phase_d == PhPath) || (phase_d == PhDone);
      mc         = past_after ? mfound_d : MethodNone;
      has_body   = (mc == MethodPost) && (blank_d == BlankFound);
      work_o.has_final   = 1'b1;
      work_o.method_code = mc;
      work_o.body_offset = has_body ? body_d : '0;
      if (!past_after) begin
        work_o.status_code = StatusNoMethod;
      end else if (mc == MethodPost && !has_body) begin
        work_o.status_code = StatusNoBody;
      end else if (!pstart_d) begin
        work_o.status_code = StatusNoPath;
      end else if (plen_d >= path_limit_q) begin
        work_o.status_code = StatusTooLong;
      end else begin
        work_o.status_code = StatusOk;
      end
      // The buffer is over: start the next one from scratch.
      phase_d  = PhSpace;
      prog_d   = 3'd0;
      mfound_d = MethodNone;
      pos_d    = '0;
      plen_d   = '0;
      blank_d  = BlankNone;
      body_d   = '0;
      pstart_d = 1'b0;
    end else begin
      past_after = 1'b0;
    end
  end

  assign push_o = accept_i && (work_o.has_path || work_o.has_final);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_limit_q <= PathLimitReset;
      phase_q      <= PhSpace;
      prog_q       <= 3'd0;
      mfound_q     <= MethodNone;
      pos_q        <= '0;
      plen_q       <= '0;
      blank_q      <= BlankNone;
      body_q       <= '0;
      pstart_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        path_limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q  <= phase_d;
        prog_q   <= prog_d;
        mfound_q <= mfound_d;
        pos_q    <= pos_d;
        plen_q   <= plen_d;
        blank_q  <= blank_d;
        body_q   <= body_d;
        pstart_q <= pstart_d;
      end
    end
  end

endmodule

FILE: sv/hrlp_fifo.sv
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps

module hrlp_fifo import hrlp_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  input  logic  pop_i,
  output work_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  work_t           store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: sv/hrlp_back.sv
// Back end: turns queue entries into result beats behind an output register.
`timescale 1ns / 1ps

module hrlp_back import hrlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  work_t     head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic      out_valid_q;
  out_beat_t out_beat_q, out_beat_d;
  logic      path_sent_q, path_sent_d;
  logic      load;
  logic      emit_path;

  // An entry with both a path byte and the final status is sent in two beats.
  assign load      = (!out_valid_q || out_ready_i) && !empty_i;
  assign emit_path = head_i.has_path && !path_sent_q;
  assign pop_o     = load && !(emit_path && head_i.has_final);

  always_comb begin
    out_beat_d  = '0;
    path_sent_d = path_sent_q;
    if (emit_path) begin
      out_beat_d.result_kind = KindPath;
      out_beat_d.path_byte   = head_i.path_byte;
      out_beat_d.method_code = head_i.method_code;
      out_beat_d.status_code = StatusOk;
    end else begin
      out_beat_d.result_kind = KindFinal;
      out_beat_d.method_code = head_i.method_code;
      out_beat_d.status_code = head_i.status_code;
      out_beat_d.body_offset = head_i.body_offset;
      out_beat_d.run_end     = 1'b1;
    end
    if (load) begin
      path_sent_d = emit_path && head_i.has_final;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_beat_q <= out_beat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      path_sent_q <= 1'b0;
    end else begin
      path_sent_q <= path_sent_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

FILE: sv/http_request_line_parser.sv
// Top level of the HTTP request line parser.
`timescale 1ns / 1ps

// The parser takes one request byte per beat, with last_byte set on the final
// byte of the buffer, and produces one path-byte result for every byte of the
// path plus one final status result per buffer. It sustains one input byte per
// clock cycle while the queue has room: the front end updates the whole parse
// state for every accepted byte, so any byte may follow the previous one
// directly. Each result beat passes through the queue storage and the back
// end's output register. The only byte that needs two output beats is a final
// byte that is also a path byte; that beat pair is drained by the back end
// while the front end keeps accepting into the queue, whose depth (QueueDepth)
// sets how many result-producing bytes an output stall absorbs before
// in_ready_o drops. The path_limit register is written with cfg_we_i and should
// only change while the block is idle. There is no clearing pass after reset.

module http_request_line_parser import hrlp_pkg::*; #(
  parameter int MaxRequestBytes = MaxRequestBytesDef,
  parameter int QueueDepth      = QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [PathLimitW-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_beat_o
);

  logic  accept;
  logic  push;
  work_t work;
  work_t head;
  logic  full;
  logic  empty;
  logic  pop;

  // A byte is taken whenever the queue has room; bytes that cause no result
  // are dropped by the front end after they update the parse state.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  hrlp_front #(
    .MaxRequestBytes(MaxRequestBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_beat_i  (in_beat_i),
    .push_o     (push),
    .work_o     (work)
  );

  hrlp_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(work),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  // The back end presents each queued entry as one or two result beats.
  hrlp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

endmodule

FILE: sv/hrlp_checker.sv
// Port-level assertion checker for the request line parser, with its bind.
`timescale 1ns / 1ps
`include "http_request_line_parser_assert.svh"

module hrlp_checker import hrlp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_beat_o
);

  logic path_beat;
  logic final_beat;
  logic path_fields_clear;
  logic body_seen;
  logic body_allowed;

  assign path_beat         = out_valid_o && (out_beat_o.result_kind == KindPath);
  assign final_beat        = out_valid_o && (out_beat_o.result_kind == KindFinal);
  assign path_fields_clear = !out_beat_o.run_end && (out_beat_o.status_code == StatusOk) &&
                             (out_beat_o.body_offset == '0);
  assign body_seen         = out_valid_o && (out_beat_o.body_offset != '0);
  assign body_allowed      = (out_beat_o.method_code == MethodPost) &&
                             (out_beat_o.status_code != StatusNoBody) &&
                             (out_beat_o.status_code != StatusNoMethod);

  // A stalled result beat holds.
  `HRLP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))

  // Path beats never carry final-status information.
  `HRLP_ASSERT(a_path_clean, path_beat |-> path_fields_clear)

  // Final beats end the run and carry no path byte.
  `HRLP_ASSERT(a_final_shape, final_beat |-> out_beat_o.run_end && out_beat_o.path_byte == 8'h00)

  // A body offset is only reported for a POST that found its body.
  `HRLP_ASSERT(a_body_post, body_seen |-> body_allowed)

  // Without a method there is no method code.
  `HRLP_ASSERT(a_no_method, out_valid_o && out_beat_o.status_code == StatusNoMethod |-> out_beat_o.method_code == MethodNone)

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);

FILE: tb/sv/request_line_checker.sv
// Checker that predicts and compares the result beats of the request line parser.
`timescale 1ns / 1ps

module request_line_checker import hrlp_pkg::*; #(
  parameter int MaxRequestBytes = MaxRequestBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [PathLimitW-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_beat_t              in_beat_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_beat_t             out_beat_i,
  output int unsigned           pending_o,
  output int unsigned           mismatch_count_o
);

  localparam logic [PosW-1:0] PosSat = PosW'(MaxRequestBytes);

  // Predicted parse state, one buffer at a time.
  phase_e                parse_at;
  logic [2:0]            letters_matched;
  logic [1:0]            method_seen;
  logic [PosW-1:0]       byte_index;
  logic [PathLimitW-1:0] path_bytes;
  logic [2:0]            blank_progress;
  logic [PosW-1:0]       body_index;
  logic                  path_seen;
  logic [PathLimitW-1:0] path_limit;

  out_beat_t   expected_beats[$];
  out_beat_t   wanted;
  int unsigned mismatch_total;

  function automatic string method_word(logic [1:0] code);
    string word;
    case (code)
      MethodGet:     word = "get";
      MethodPost:    word = "post";
      MethodOptions: word = "options";
      default:       word = "";
    endcase
    return word;
  endfunction

  function automatic logic beyond_method(phase_e ph);
    return (ph == PhSeek) || (ph == PhPath) || (ph == PhDone);
  endfunction

  function automatic out_beat_t path_beat(logic [7:0] b);
    out_beat_t beat;
    beat             = '0;
    beat.result_kind = KindPath;
    beat.path_byte   = b;
    beat.method_code = method_seen;
    return beat;
  endfunction

  task automatic clear_parse();
    parse_at        = PhSpace;
    letters_matched = '0;
    method_seen     = MethodNone;
    byte_index      = '0;
    path_bytes      = '0;
    blank_progress  = BlankNone;
    body_index      = '0;
    path_seen       = 1'b0;
  endtask

  // A method is only complete when another byte follows its last letter.
  task automatic advance_method(input logic [7:0] b, input logic is_last);
    string word;
    word = method_word(method_seen);
    if (letters_matched < word.len() && (b | CaseBit) == word[letters_matched]) begin
      letters_matched++;
      if (letters_matched == word.len()) begin
        if (is_last) begin
          parse_at    = PhFail;
          method_seen = MethodNone;
        end else begin
          parse_at = PhSeek;
        end
      end
    end else begin
      parse_at    = PhFail;
      method_seen = MethodNone;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    phase_e     entry_phase;
    logic [7:0] lower;
    logic       method_ok;
    logic [1:0] code;
    logic       body_ok;
    out_beat_t  beat;
    entry_phase = parse_at;
    case (entry_phase)
      PhSpace: begin
        if (b != ByteSpace) begin
          lower = b | CaseBit;
          if (lower == "g") method_seen = MethodGet;
          else if (lower == "p") method_seen = MethodPost;
          else if (lower == "o") method_seen = MethodOptions;
          else method_seen = MethodNone;
          letters_matched = '0;
          parse_at        = PhMethod;
          advance_method(b, is_last);
        end
      end
      PhMethod: advance_method(b, is_last);
      PhSeek: begin
        if (b == ByteSlash && !is_last) begin
          path_seen  = 1'b1;
          path_bytes = PathLimitW'(1);
          parse_at   = PhPath;
          expected_beats.push_back(path_beat(b));
        end
      end
      PhPath: begin
        if (b == ByteSpace || b == ByteCr || b == ByteLf || b == ByteQmark) begin
          parse_at = PhDone;
        end else begin
          if (path_bytes != PathLenSat) path_bytes++;
          expected_beats.push_back(path_beat(b));
        end
      end
      default: ;
    endcase

    if (beyond_method(entry_phase) && method_seen == MethodPost &&
        blank_progress != BlankFound) begin
      if (b == ByteCr) begin
        blank_progress = (blank_progress == BlankCrLf) ? BlankCrLfCr : BlankCr;
      end else if (b == ByteLf) begin
        blank_progress = (blank_progress == BlankCr)     ? BlankCrLf  :
                         (blank_progress == BlankCrLfCr) ? BlankFound : BlankNone;
      end else begin
        blank_progress = BlankNone;
      end
      if (blank_progress == BlankFound) begin
        if (is_last) blank_progress = BlankNone;
        else body_index = (byte_index < PosSat) ? byte_index + 1'b1 : PosSat;
      end
    end

    if (byte_index < PosSat) byte_index++;

    if (is_last) begin
      method_ok = beyond_method(parse_at);
      code      = method_ok ? method_seen : MethodNone;
      body_ok   = (code == MethodPost) && (blank_progress == BlankFound);
      beat             = '0;
      beat.result_kind = KindFinal;
      beat.method_code = code;
      beat.body_offset = body_ok ? body_index : '0;
      beat.run_end     = 1'b1;
      if (!method_ok) beat.status_code = StatusNoMethod;
      else if (code == MethodPost && !body_ok) beat.status_code = StatusNoBody;
      else if (!path_seen) beat.status_code = StatusNoPath;
      else if (path_bytes >= path_limit) beat.status_code = StatusTooLong;
      else beat.status_code = StatusOk;
      expected_beats.push_back(beat);
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      path_limit = PathLimitReset;
      expected_beats.delete();
      mismatch_total = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat 0x%0h arrived with nothing expected", out_beat_i);
          mismatch_total++;
        end else begin
          wanted = expected_beats.pop_front();
          check_field("result_kind", wanted.result_kind, out_beat_i.result_kind);
          check_field("path_byte", wanted.path_byte, out_beat_i.path_byte);
          check_field("method_code", wanted.method_code, out_beat_i.method_code);
          check_field("status_code", wanted.status_code, out_beat_i.status_code);
          check_field("body_offset", wanted.body_offset, out_beat_i.body_offset);
          check_field("run_end", wanted.run_end, out_beat_i.run_end);
        end
      end
      if (cfg_we_i) path_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_byte(in_beat_i.data_byte, in_beat_i.last_byte);
    end
    pending_o        <= expected_beats.size();
    mismatch_count_o <= mismatch_total;
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the request line parser.
`timescale 1ns / 1ps

module testbench;
  import hrlp_pkg::*;

  // The block holds at most QueueDepth entries in its queue plus one beat in
  // its output register, so a short settle covers anything in flight.
  localparam int SettleCycles = 16;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HoldCycles = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [PathLimitW-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_beat;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_beat;

  int unsigned pending;
  int unsigned mismatch_count;

  // Idle rates in percent for the sender and the receiver. Only the stimulus
  // process writes them; the receiver process reads its own rate.
  int unsigned tx_idle_pct = 13;
  int unsigned rx_idle_pct = 84;
  // The stimulus asks for a long hold-off by bumping holds_wanted; the
  // receiver process grants it and counts the grants in holds_done.
  int unsigned holds_wanted = 0;
  int unsigned holds_done = 0;
  int unsigned bytes_sent = 0;

  logic [7:0] request_bytes[$];

  always #5 clk = ~clk;

  http_request_line_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  request_line_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_beat_i        (in_beat),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_beat_i       (out_beat),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  // Offer one byte and hold it until the block takes it. The idle gap comes
  // before valid is raised, so a valid that stays high between back-to-back
  // beats is never lowered and raised in the same time step.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: b, last_byte: is_last};
    do @(posedge clk); while (!in_ready);
  endtask

  // Send the composed buffer, with last_byte set on its final byte.
  task automatic send_request();
    int i;
    for (i = 0; i < request_bytes.size(); i++) begin
      send_byte(request_bytes[i], i == request_bytes.size() - 1);
    end
    bytes_sent += request_bytes.size();
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) request_bytes.push_back(s[i]);
  endtask

  task automatic push_blank_line();
    request_bytes.push_back(ByteCr);
    request_bytes.push_back(ByteLf);
    request_bytes.push_back(ByteCr);
    request_bytes.push_back(ByteLf);
  endtask

  // Stop offering beats, wait for every expected result, then let the block
  // finish anything that produces no result.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // The path limit is only changed while the block is idle.
  task automatic reconfigure(input logic [PathLimitW-1:0] limit);
    wait_until_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Build one random buffer. Most are well-formed requests with random case,
  // path content and header lines, so that the path and blank line logic is
  // reached; the rest are noise, truncated methods or misspelled methods.
  task automatic compose_request();
    int         shape;
    int         cut;
    int         bad_at;
    int         i;
    int         path_chars;
    string      word;
    logic [1:0] code;
    logic [7:0] ch;
    request_bytes.delete();
    repeat ($urandom_range(0, 2)) request_bytes.push_back(ByteSpace);
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      // Pure noise; now and then it starts with a method letter by chance.
      repeat ($urandom_range(1, 12)) request_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end

    code = 2'($urandom_range(1, 3));
    case (code)
      MethodGet:  word = "get";
      MethodPost: word = "post";
      default:    word = "options";
    endcase
    cut    = word.len();
    bad_at = -1;
    if (shape < 25) begin
      if ($urandom_range(0, 1)) cut = $urandom_range(1, word.len() - 1);
      else bad_at = $urandom_range(0, word.len() - 1);
    end
    for (i = 0; i < cut; i++) begin
      ch = word[i];
      if ($urandom_range(0, 1)) ch = ch & ~CaseBit;
      if (i == bad_at) ch = 8'($urandom_range(0, 255));
      request_bytes.push_back(ch);
    end
    // A buffer may simply end in the middle of the method.
    if (cut < word.len() && $urandom_range(0, 1)) return;

    // Bytes between the method and the slash are skipped by the block.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) request_bytes.push_back(8'($urandom_range(0, 255)));
    end

    if ($urandom_range(0, 9) != 0) begin
      request_bytes.push_back(ByteSlash);
      path_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      repeat (path_chars) begin
        if ($urandom_range(0, 6) == 0) request_bytes.push_back(8'($urandom_range(0, 255)));
        else request_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
      end
      // End the path with each terminator, or let the buffer end inside it.
      case ($urandom_range(0, 4))
        0: return;
        1: request_bytes.push_back(ByteSpace);
        2: request_bytes.push_back(ByteQmark);
        3: request_bytes.push_back(ByteCr);
        default: request_bytes.push_back(ByteLf);
      endcase
    end

    // Header lines and a blank line: almost always for POST, sometimes for the
    // others. An empty body puts the blank line right on the final byte.
    if ((code == MethodPost) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 3) == 0)) begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 5))
          0: request_bytes.push_back(ByteCr);
          1: request_bytes.push_back(ByteLf);
          default: request_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
        endcase
      end
      push_blank_line();
      repeat ($urandom_range(0, 3)) request_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // One stretch of random traffic at fixed idle rates, split into four blocks
  // with a fresh path limit each, covering a limit of one, 4096, small limits
  // and any nonzero 13-bit value.
  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned budget, input bit squeeze);
    int unsigned           blk;
    int unsigned           goal;
    logic [PathLimitW-1:0] limit;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (blk = 0; blk < 4; blk++) begin
      case ($urandom_range(0, 3))
        0: limit = PathLimitW'(1);
        1: limit = PathLimitW'(4096);
        2: limit = PathLimitW'($urandom_range(2, 24));
        default: limit = PathLimitW'($urandom_range(1, 8191));
      endcase
      reconfigure(limit);
      // With the receiver held off, the queue fills and in_ready must drop.
      if (squeeze && blk == 1) holds_wanted++;
      goal = bytes_sent + budget / 4;
      while (bytes_sent < goal) begin
        compose_request();
        send_request();
      end
    end
  endtask

  // Receiver: random stalls at the current rate, plus the long hold-off on
  // request, counted here in cycles.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_wanted) begin
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers at the reset limit. A leading space and mixed case GET
    // whose final byte is the all-ones path byte, so it yields two beats.
    request_bytes.delete();
    push_text(" gEt/");
    request_bytes.push_back(8'hFF);
    send_request();
    // POST with a body that starts with the all-zero byte.
    request_bytes.delete();
    push_text("Post/");
    push_blank_line();
    request_bytes.push_back(8'h00);
    send_request();
    // The method's last letter is the final byte: no method.
    request_bytes.delete();
    push_text("get");
    send_request();
    // A slash on the final byte does not start a path.
    request_bytes.delete();
    push_text("OPTIONS/");
    send_request();

    // A limit of one: even a lone slash is too long.
    reconfigure(PathLimitW'(1));
    request_bytes.delete();
    push_text("get/?");
    send_request();
    // A zero limit makes every path too long.
    reconfigure(PathLimitW'(0));
    request_bytes.delete();
    push_text("get/x");
    send_request();

    run_phase(13, 84, 340, 1'b0);
    run_phase(84, 13, 340, 1'b0);
    run_phase(0, 0, 340, 1'b1);

    wait_until_quiet();
    if (mismatch_count == 0 && pending == 0) begin
      $display("http_request_line_parser verification clean");
    end else begin
      $display("http_request_line_parser verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(20_000_000);
    $display("http_request_line_parser verification failed");
    $finish;
  end

endmodule
